FILE: src/channel_min_max_mean_stats_core_assert.svh
// ----------------------------------------------------------------------------
// channel min/max/mean statistics - assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CHANNEL_MIN_MAX_MEAN_STATS_CORE_ASSERT_SVH
`define CHANNEL_MIN_MAX_MEAN_STATS_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define CMMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always active
`define CMMS_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cmms_pkg.sv
// ----------------------------------------------------------------------------
// cmms_pkg
// types and constants shared by the statistics core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmms_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = 56;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int MAX_REPORT  = 16;

    localparam logic [SAMPLE_W-1:0] MEAN_MAX = '1;

    // command codes of an input item
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_FULL   = 2'd1;
    localparam logic [1:0] CMD_MEAN   = 2'd2;

    // operation codes in the queue
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_FULL   = 2'd1;
    localparam logic [1:0] OP_MEAN   = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [3:0]          channel;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [3:0]          report_channel;
        logic [SAMPLE_W-1:0] max_value;
        logic [SAMPLE_W-1:0] min_value;
        logic [SAMPLE_W-1:0] mean_value;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [3:0]          channel;
        logic [SAMPLE_W-1:0] sample;
    } op_entry_t;

endpackage

`default_nettype wire

FILE: src/cmms_front.sv
// ----------------------------------------------------------------------------
// cmms_front
// accepts items, drops those with no effect, queues the rest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmms_front #(
    parameter int CHANNELS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  cmms_pkg::in_item_t  s_item,
    input  wire                 q_full,
    output logic                q_push,
    output cmms_pkg::op_entry_t q_entry
);
    import cmms_pkg::*;

    localparam logic [5:0] CH_LIMIT = 6'(CHANNELS);

    logic keep;
    logic [1:0] op;

    always_comb begin
        keep = 1'b0;
        op   = OP_SAMPLE;
        unique case (s_item.cmd)
            CMD_SAMPLE: begin
                keep = (6'(s_item.channel) < CH_LIMIT);
                op   = OP_SAMPLE;
            end
            CMD_FULL: begin
                keep = 1'b1;
                op   = OP_FULL;
            end
            CMD_MEAN: begin
                keep = 1'b1;
                op   = OP_MEAN;
            end
            default: begin
                keep = 1'b0;
                op   = OP_SAMPLE;
            end
        endcase
    end

    assign s_ready         = aresetn && !q_full;
    assign q_push          = s_valid && s_ready && keep;
    assign q_entry.op      = op;
    assign q_entry.channel = s_item.channel;
    assign q_entry.sample  = s_item.sample;

    logic unused_clk;
    assign unused_clk = aclk;

endmodule

`default_nettype wire

FILE: src/cmms_queue.sv
// ----------------------------------------------------------------------------
// cmms_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmms_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  cmms_pkg::op_entry_t push_entry,
    output logic                full,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output cmms_pkg::op_entry_t pop_entry
);
    import cmms_pkg::*;

    op_entry_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_pop;

    assign full      = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_entry = entry_reg[rd_ptr_reg];
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: src/cmms_back.sv
// ----------------------------------------------------------------------------
// cmms_back
// statistics store, sample update and report walk with serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmms_back #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_ready,
    input  cmms_pkg::op_entry_t q_entry,
    output logic                m_valid,
    input  wire                 m_ready,
    output cmms_pkg::out_item_t m_item
);
    import cmms_pkg::*;

    localparam int REPORTED = (CHANNELS > MAX_REPORT) ? MAX_REPORT : CHANNELS;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WK_W     = (REPORTED > 1) ? $clog2(REPORTED) : 1;
    localparam int DW       = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    localparam logic [WK_W-1:0] WALK_LAST = WK_W'(REPORTED - 1);
    localparam logic [4:0]      STEP_LAST = 5'(SAMPLE_W - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [SAMPLE_W-1:0]   max_reg   [CHANNELS];
    logic [SAMPLE_W-1:0]   min_reg   [CHANNELS];
    logic [SUM_W-1:0]      sum_reg   [CHANNELS];
    logic [COUNT_BITS-1:0] count_reg [CHANNELS];

    logic [2:0]          state_reg, state_next;
    logic [WK_W-1:0]     walk_reg, walk_next;
    logic                full_reg, full_next;
    logic [4:0]          step_reg, step_next;
    logic [DW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [SAMPLE_W-1:0] low_reg, low_next;
    logic [SAMPLE_W-1:0] quo_reg, quo_next;
    logic [SAMPLE_W-1:0] hmax_reg, hmax_next;
    logic [SAMPLE_W-1:0] hmin_reg, hmin_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           out_reg, out_next;

    logic [CH_W-1:0]       s_idx;
    logic [CH_W-1:0]       w_idx;
    logic                  do_sample;
    logic [SAMPLE_W-1:0]   upd_max, upd_min;
    logic [SUM_W:0]        sum_add;
    logic [SUM_W-1:0]      upd_sum;
    logic [COUNT_BITS-1:0] upd_count;
    logic [DW:0]           rem_shift, rem_diff;
    logic                  rem_ge;
    logic                  emit_go;
    logic                  do_clear;

    assign s_idx = CH_W'(q_entry.channel);
    assign w_idx = CH_W'(walk_reg);

    // sample update of one channel
    always_comb begin
        upd_max   = (q_entry.sample > max_reg[s_idx]) ? q_entry.sample : max_reg[s_idx];
        upd_min   = ((q_entry.sample < min_reg[s_idx]) || (min_reg[s_idx] == '0))
                    ? q_entry.sample : min_reg[s_idx];
        sum_add   = {1'b0, sum_reg[s_idx]} + (SUM_W+1)'(q_entry.sample);
        upd_sum   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        upd_count = (&count_reg[s_idx]) ? count_reg[s_idx] : count_reg[s_idx] + 1'b1;
    end

    // one restoring division step
    always_comb begin
        rem_shift = {rem_reg, low_reg[SAMPLE_W-1]};
        rem_diff  = rem_shift - {1'b0, cnt_reg};
        rem_ge    = (rem_shift >= {1'b0, cnt_reg});
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign do_sample = q_ready && q_valid && (q_entry.op == OP_SAMPLE);
    assign emit_go   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign do_clear  = (state_reg == ST_CLEAR);

    always_comb begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        full_next    = full_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quo_next     = quo_reg;
        hmax_next    = hmax_reg;
        hmin_next    = hmin_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_entry.op != OP_SAMPLE) && (count_reg[0] != '0)) begin
                    full_next  = (q_entry.op == OP_FULL);
                    walk_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cnt_next  = DW'(count_reg[w_idx]);
                rem_next  = DW'(sum_reg[w_idx][SUM_W-1:SAMPLE_W]);
                low_next  = sum_reg[w_idx][SAMPLE_W-1:0];
                hmax_next = max_reg[w_idx];
                hmin_next = min_reg[w_idx];
                step_next = '0;
                if (count_reg[w_idx] == '0) begin
                    quo_next   = '0;
                    state_next = ST_EMIT;
                end else if (DW'(sum_reg[w_idx][SUM_W-1:SAMPLE_W]) >=
                             DW'(count_reg[w_idx])) begin
                    quo_next   = MEAN_MAX;
                    state_next = ST_EMIT;
                end else begin
                    quo_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
                quo_next  = {quo_reg[SAMPLE_W-2:0], rem_ge};
                low_next  = {low_reg[SAMPLE_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    m_valid_next           = 1'b1;
                    out_next.report_channel = 4'(walk_reg);
                    out_next.max_value      = full_reg ? hmax_reg : '0;
                    out_next.min_value      = full_reg ? hmin_reg : '0;
                    out_next.mean_value     = quo_reg;
                    out_next.last           = (walk_reg == WALK_LAST);
                    if (walk_reg == WALK_LAST) begin
                        state_next = ST_CLEAR;
                    end else begin
                        walk_next  = walk_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_CLEAR: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            walk_reg    <= '0;
            full_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            full_reg    <= full_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        hmax_reg <= hmax_next;
        hmin_reg <= hmin_next;
        out_reg  <= out_next;
    end

    // statistics store
    always_ff @(posedge aclk) begin
        if (!aresetn || do_clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
                max_reg[i]   <= '0;
                min_reg[i]   <= '0;
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else if (do_sample) begin
            max_reg[s_idx]   <= upd_max;
            min_reg[s_idx]   <= upd_min;
            sum_reg[s_idx]   <= upd_sum;
            count_reg[s_idx] <= upd_count;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

FILE: src/channel_min_max_mean_stats_core.sv
// ----------------------------------------------------------------------------
// channel_min_max_mean_stats_core
// per-channel max, min and mean of 24-bit unsigned samples
// ----------------------------------------------------------------------------
// A sample item updates one channel's maximum, minimum, saturating sum and
// saturating count as it leaves the four-entry command queue; a sample
// item can therefore be taken every cycle while the queue has room. A report
// item walks channels 0 to min(CHANNELS,16)-1; if channel 0 has no samples,
// the report item is taken from the queue and dropped. For each channel the
// walk loads the statistics, runs the 24 steps of the one-bit-per-cycle
// restoring divider and emits a result; a channel with a zero count or a
// mean too large for 24 bits skips the divider. After the last channel the
// walk clears every channel. The result register lets the next channel's
// division run while a result waits. Items are queued ahead of the report
// walk, so input is taken until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module channel_min_max_mean_stats_core #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  cmms_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output cmms_pkg::out_item_t m_item
);
    import cmms_pkg::*;

    logic      q_full;
    logic      q_push;
    op_entry_t q_push_entry;
    logic      q_valid;
    logic      q_ready;
    op_entry_t q_pop_entry;

    cmms_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_push_entry)
    );

    cmms_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_pop_entry)
    );

    cmms_back #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_pop_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

FILE: src/cmms_checker.sv
// ----------------------------------------------------------------------------
// cmms_checker
// port-level checks of the statistics core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "channel_min_max_mean_stats_core_assert.svh"

module cmms_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input cmms_pkg::in_item_t  s_item,
    input wire                 m_valid,
    input wire                 m_ready,
    input cmms_pkg::out_item_t m_item
);
    import cmms_pkg::*;

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ (^s_item);

    `CMMS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_item), "result changed while stalled")

    `CMMS_ASSERT_NOW(a_min_le_max, aclk, aresetn, m_valid,
        m_item.min_value <= m_item.max_value, "minimum above maximum")

    `CMMS_ASSERT_NOW(a_top_is_last, aclk, aresetn, m_valid && !m_item.last,
        m_item.report_channel != 4'd15, "channel 15 not marked last")

    `CMMS_ASSERT_NEXT_ANY(a_reset_idle, aclk, !aresetn,
        !m_valid, "result valid after reset")

endmodule

bind channel_min_max_mean_stats_core cmms_checker u_checker (.*);

`default_nettype wire
